[sv/lzw_byte_compressor_macros.svh]
// Assertion macros for the file that checks the compressor.
`ifndef LZW_BYTE_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_MACROS_SVH

`define LZW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define LZW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/lzw_pkg.sv]
`timescale 1ns / 1ps
package lzw_pkg;

  localparam int unsigned FIRST_FREE = 256;
  localparam int unsigned OUT_W      = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH_RD,
    ST_ENT_RD,
    ST_CHECK,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic accept;
    logic probe;
    logic hit;
    logic emit_miss;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic prefix_valid;
    logic is_last;
    logic occupied;
    logic match;
    logic out_free;
  } sts_t;

endpackage

[sv/lzw_if.sv]
`timescale 1ns / 1ps
interface lzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface lzw_code_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_code;
  logic        end_of_stream;
  modport source (output valid, output out_code, output end_of_stream, input ready);
  modport sink (input valid, input out_code, input end_of_stream, output ready);
endinterface

[sv/lzw_ram.sv]
`timescale 1ns / 1ps
module lzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lzw_ctrl.sv]
`timescale 1ns / 1ps
module lzw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzw_pkg::sts_t sts,
  output lzw_pkg::cmd_t cmd
);

  lzw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzw_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.prefix_valid) begin
            state_nxt = lzw_pkg::ST_HASH_RD;
          end else if (sts.is_last) begin
            state_nxt = lzw_pkg::ST_EMIT_LAST;
          end
        end
      end
      lzw_pkg::ST_HASH_RD: state_nxt = lzw_pkg::ST_ENT_RD;
      lzw_pkg::ST_ENT_RD:  state_nxt = lzw_pkg::ST_CHECK;
      lzw_pkg::ST_CHECK: begin
        if (sts.match) begin
          state_nxt = sts.is_last ? lzw_pkg::ST_EMIT_LAST : lzw_pkg::ST_IDLE;
        end else if (sts.occupied) begin
          state_nxt = lzw_pkg::ST_HASH_RD;
        end else begin
          state_nxt = lzw_pkg::ST_EMIT_MISS;
        end
      end
      lzw_pkg::ST_EMIT_MISS: begin
        if (sts.out_free) begin
          state_nxt = sts.is_last ? lzw_pkg::ST_EMIT_LAST : lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_EMIT_LAST: begin
        if (sts.out_free) begin
          state_nxt = lzw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lzw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      lzw_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lzw_pkg::ST_CHECK: begin
        cmd.hit   = sts.match;
        cmd.probe = !sts.match && sts.occupied;
      end
      lzw_pkg::ST_EMIT_MISS: cmd.emit_miss = sts.out_free;
      lzw_pkg::ST_EMIT_LAST: cmd.emit_last = sts.out_free;
      default: ;
    endcase
  end

endmodule

[sv/lzw_dpath.sv]
`timescale 1ns / 1ps
module lzw_dpath #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lzw_pkg::cmd_t cmd,
  output lzw_pkg::sts_t sts,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   out_code,
  output logic          out_eos
);

  localparam int unsigned CW = $clog2(DICT_SIZE);
  localparam int unsigned NW = CW + 1;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned HS = 2 ** SW;
  localparam int unsigned EW = CW + 8 + SW;
  localparam logic [NW-1:0] DSZ = NW'(DICT_SIZE);
  localparam logic [NW-1:0] FF_N = NW'(lzw_pkg::FIRST_FREE);
  localparam logic [CW-1:0] FF_C = CW'(lzw_pkg::FIRST_FREE);

  logic [7:0]    byte_r;
  logic          last_r;
  logic [CW-1:0] prefix_r;
  logic          pvalid_r;
  logic [NW-1:0] nfc_r;
  logic [SW-1:0] slot_r;
  logic [11:0]   ocode_r;
  logic          oeos_r;
  logic          ovalid_r;

  logic [CW-1:0] h_rdata;
  logic [EW-1:0] e_rdata;
  logic [EW-1:0] e_wdata;
  logic          ins_we;
  logic          out_free;
  logic [SW-1:0] hash;
  logic [CW-1:0] e_prefix;
  logic [7:0]    e_byte;
  logic [SW-1:0] e_slot;

  assign hash = SW'(prefix_r) ^ (SW'(in_byte) << (SW - 8));
  assign {e_prefix, e_byte, e_slot} = e_rdata;
  assign e_wdata  = {prefix_r, byte_r, slot_r};
  assign ins_we   = cmd.emit_miss && (nfc_r < DSZ);
  assign out_free = !ovalid_r || out_ready;

  lzw_ram #(.WIDTH(CW), .DEPTH(HS)) u_hash (
    .clk(clk), .we(ins_we), .waddr(slot_r), .wdata(nfc_r[CW-1:0]),
    .raddr(slot_r), .rdata(h_rdata)
  );

  lzw_ram #(.WIDTH(EW), .DEPTH(DICT_SIZE)) u_ent (
    .clk(clk), .we(ins_we), .waddr(nfc_r[CW-1:0]), .wdata(e_wdata),
    .raddr(h_rdata), .rdata(e_rdata)
  );

  always_comb begin
    sts.prefix_valid = pvalid_r;
    sts.is_last      = cmd.accept ? in_last : last_r;
    sts.occupied     = (h_rdata >= FF_C) && ({1'b0, h_rdata} < nfc_r) && (e_slot == slot_r);
    sts.match        = sts.occupied && (e_prefix == prefix_r) && (e_byte == byte_r);
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
      nfc_r    <= FF_N;
      ovalid_r <= 1'b0;
      prefix_r <= '0;
    end else begin
      if (cmd.emit_miss || cmd.emit_last) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (cmd.accept && !pvalid_r) begin
        prefix_r <= CW'(in_byte);
        pvalid_r <= 1'b1;
      end
      if (cmd.hit) begin
        prefix_r <= h_rdata;
      end
      if (cmd.emit_miss) begin
        prefix_r <= CW'(byte_r);
        if (ins_we) begin
          nfc_r <= nfc_r + NW'(1);
        end
      end
      if (cmd.emit_last) begin
        prefix_r <= '0;
        pvalid_r <= 1'b0;
        nfc_r    <= FF_N;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
      slot_r <= hash;
    end else if (cmd.probe) begin
      slot_r <= slot_r + SW'(1);
    end
    if (cmd.emit_miss) begin
      ocode_r <= 12'(prefix_r);
      oeos_r  <= 1'b0;
    end else if (cmd.emit_last) begin
      ocode_r <= 12'(prefix_r);
      oeos_r  <= 1'b1;
    end
  end

  assign out_valid = ovalid_r;
  assign out_code  = ocode_r;
  assign out_eos   = oeos_r;

endmodule

[sv/lzw_byte_compressor.sv]
`timescale 1ns / 1ps
// Channel   Direction  Contents
// in_ch     sink       data_byte[7:0], is_last
// out_ch    source     out_code[11:0], end_of_stream
// A byte that extends a prefix is looked up by hash read, entry read and compare;
// each further probe of the hash table repeats those three steps in that order.
// A miss adds a state that emits the code, and a last byte one that ends the stream.
// The result register lets a new byte be taken while a code awaits transfer; the
// block stalls only when it must load a code while the register is still full.
// After reset the dictionary is empty at once: no clearing pass is needed.
`include "lzw_byte_compressor_macros.svh"
module lzw_byte_compressor #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input logic      clk,
  input logic      rst_n,
  lzw_byte_if.sink   in_ch,
  lzw_code_if.source out_ch
);

  lzw_pkg::cmd_t cmd;
  lzw_pkg::sts_t sts;

  lzw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  lzw_dpath #(.DICT_SIZE(DICT_SIZE)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_byte(in_ch.data_byte), .in_last(in_ch.is_last),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_code(out_ch.out_code), .out_eos(out_ch.end_of_stream)
  );

  `LZW_ASSERT_IMPL(a_no_overwrite, cmd.emit_miss || cmd.emit_last, sts.out_free, "Result register overwritten.")
  `LZW_ASSERT_NEXT(a_stream_reset, cmd.emit_last, !sts.prefix_valid, "Prefix kept after end of stream.")
  `LZW_ASSERT_IMPL(a_one_action, cmd.hit || cmd.probe, !cmd.accept && !(cmd.hit && cmd.probe), "Conflicting commands.")

endmodule
